// ===== rtl/core/utf8_stream_validator_macros.svh =====
// Assertion macros for the checker file of the validator.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// Both macros expect clk and arst_n in scope.
`define UTV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8_stream_validator: same-cycle check failed");

`define UTV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8_stream_validator: next-cycle check failed");

`endif

// ===== rtl/core/utv_pkg.sv =====
package utv_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
	localparam int unsigned POINT_W = 21;

	typedef enum logic [2:0] {
		KIND_ASCII,
		KIND_LEAD2,
		KIND_LEAD3,
		KIND_LEAD4,
		KIND_CONT,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] bits;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// ===== rtl/core/utf8_stream_validator.sv =====
// Strict UTF-8 stream validator.
// Input channel: one byte per beat on data_byte, with final_byte high on the
// last byte of a stream. A beat is taken when push is high and full is low.
// Result channel: one stream_valid verdict per stream, given for its final
// byte. The verdict is shown while empty is low and leaves when pop is high.
// A final byte passes through the byte queue and then the result queue before its
// verdict shows. Throughput: one byte per cycle unless a final byte waits on a full
// result queue, set by the decoder that updates its state once per cycle; the
// classifier and decoder are parted by a two-entry queue.
// When the receiver stalls, verdicts collect in a two-entry result queue;
// once that is full the decoder holds the next final byte, the byte queue
// fills, and full rises.
// Reset clears both queues and the decoder state; no clearing pass is needed,
// and a byte may be pushed in the first cycle after reset is released.
module utf8_stream_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic       stream_valid
);
	import utv_pkg::*;

	qstat_t qstat;
	beat_t  wr_beat;
	beat_t  rd_beat;
	logic   wr_en;
	logic   rd_en;

	utv_front u_front (
		.push       (push),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.qstat      (qstat),
		.full       (full),
		.wr_en      (wr_en),
		.wr_beat    (wr_beat)
	);

	utv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_beat (wr_beat),
		.rd_en   (rd_en),
		.rd_beat (rd_beat),
		.stat    (qstat)
	);

	utv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.rd_beat      (rd_beat),
		.rd_en        (rd_en),
		.pop          (pop),
		.empty        (empty),
		.stream_valid (stream_valid)
	);

endmodule

// ===== rtl/core/utv_front.sv =====
module utv_front (
	input  logic           push,
	input  logic [7:0]     data_byte,
	input  logic           final_byte,
	input  utv_pkg::qstat_t qstat,
	output logic           full,
	output logic           wr_en,
	output utv_pkg::beat_t wr_beat
);
	import utv_pkg::*;

	assign full  = qstat.full;
	assign wr_en = push && !qstat.full;

	always_comb begin
		wr_beat.last = final_byte;
		wr_beat.bits = 6'd0;
		priority if (data_byte[7] == 1'b0) begin
			wr_beat.kind = KIND_ASCII;
		end else if (data_byte[7:5] == 3'b110) begin
			wr_beat.kind = KIND_LEAD2;
			wr_beat.bits = {1'b0, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			wr_beat.kind = KIND_LEAD3;
			wr_beat.bits = {2'b00, data_byte[3:0]};
		end else if (data_byte[7:3] == 5'b11110) begin
			wr_beat.kind = KIND_LEAD4;
			wr_beat.bits = {3'b000, data_byte[2:0]};
		end else if (data_byte[7:6] == 2'b10) begin
			wr_beat.kind = KIND_CONT;
			wr_beat.bits = data_byte[5:0];
		end else begin
			wr_beat.kind = KIND_BAD;
		end
	end

endmodule

// ===== rtl/core/utv_queue.sv =====
module utv_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  utv_pkg::beat_t  wr_beat,
	input  logic            rd_en,
	output utv_pkg::beat_t  rd_beat,
	output utv_pkg::qstat_t stat
);
	import utv_pkg::*;

	beat_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_beat    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(wr_en) - QCNT_W'(rd_en);
		end
	end

endmodule

// ===== rtl/core/utv_back.sv =====
module utv_back (
	input  logic            clk,
	input  logic            arst_n,
	input  utv_pkg::qstat_t qstat,
	input  utv_pkg::beat_t  rd_beat,
	output logic            rd_en,
	input  logic            pop,
	output logic            empty,
	output logic            stream_valid
);
	import utv_pkg::*;

	localparam logic [POINT_W-1:0] MIN_LEN1   = POINT_W'(32'h80);
	localparam logic [POINT_W-1:0] MIN_LEN2   = POINT_W'(32'h800);
	localparam logic [POINT_W-1:0] MIN_LEN3   = POINT_W'(32'h10000);
	localparam logic [POINT_W-1:0] MAX_POINT  = POINT_W'(32'h10FFFF);
	localparam logic [POINT_W-1:0] SURR_FIRST = POINT_W'(32'hD800);
	localparam logic [POINT_W-1:0] SURR_LAST  = POINT_W'(32'hDFFF);

	function automatic logic point_ok(input logic [1:0] len, input logic [POINT_W-1:0] cp);
		logic ok;
		ok = 1'b1;
		if (len == 2'd1 && cp < MIN_LEN1) ok = 1'b0;
		if (len == 2'd2 && cp < MIN_LEN2) ok = 1'b0;
		if (len == 2'd3 && cp < MIN_LEN3) ok = 1'b0;
		if (cp > MAX_POINT) ok = 1'b0;
		if (cp >= SURR_FIRST && cp <= SURR_LAST) ok = 1'b0;
		return ok;
	endfunction

	logic [1:0]         rem_q;
	logic [1:0]         len_q;
	logic [POINT_W-1:0] point_q;
	logic               err_q;

	logic [1:0]         rem_d;
	logic [1:0]         len_d;
	logic [POINT_W-1:0] point_d;
	logic               err_d;
	logic [POINT_W-1:0] grown;
	logic               verdict;

	logic              res_mem_q [QDEPTH];
	logic [QPTR_W-1:0] res_wr_q;
	logic [QPTR_W-1:0] res_rd_q;
	logic [QCNT_W-1:0] res_cnt_q;
	logic              res_pop;
	logic              res_push;

	assign empty        = (res_cnt_q == '0);
	assign stream_valid = res_mem_q[res_rd_q];
	assign res_pop      = pop && !empty;

	// A final beat moves only when the result queue can take its verdict.
	assign rd_en    = !qstat.empty
		&& (!rd_beat.last || res_cnt_q != QCNT_W'(QDEPTH) || res_pop);
	assign res_push = rd_en && rd_beat.last;

	always_comb begin
		rem_d   = rem_q;
		len_d   = len_q;
		point_d = point_q;
		err_d   = err_q;
		grown   = {point_q[POINT_W-7:0], rd_beat.bits};
		if (rem_q == 2'd0) begin
			unique case (rd_beat.kind)
				KIND_ASCII: begin
				end
				KIND_LEAD2: begin
					rem_d   = 2'd1;
					len_d   = 2'd1;
					point_d = POINT_W'(rd_beat.bits);
				end
				KIND_LEAD3: begin
					rem_d   = 2'd2;
					len_d   = 2'd2;
					point_d = POINT_W'(rd_beat.bits);
				end
				KIND_LEAD4: begin
					rem_d   = 2'd3;
					len_d   = 2'd3;
					point_d = POINT_W'(rd_beat.bits);
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end else if (rd_beat.kind != KIND_CONT) begin
			err_d   = 1'b1;
			rem_d   = 2'd0;
			len_d   = 2'd0;
			point_d = '0;
		end else begin
			rem_d = rem_q - 2'd1;
			if (rem_q == 2'd1) begin
				if (!point_ok(len_q, grown)) err_d = 1'b1;
				len_d   = 2'd0;
				point_d = '0;
			end else begin
				point_d = grown;
			end
		end
		verdict = !err_d && (rem_d == 2'd0);
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			len_q     <= '0;
			point_q   <= '0;
			err_q     <= 1'b0;
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (rd_en) begin
				if (rd_beat.last) begin
					rem_q   <= '0;
					len_q   <= '0;
					point_q <= '0;
					err_q   <= 1'b0;
				end else begin
					rem_q   <= rem_d;
					len_q   <= len_d;
					point_q <= point_d;
					err_q   <= err_d;
				end
			end
			if (res_push) begin
				res_wr_q <= (res_wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= (res_rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : res_rd_q + 1'b1;
			end
			res_cnt_q <= res_cnt_q + QCNT_W'(res_push) - QCNT_W'(res_pop);
		end
	end

endmodule

// ===== rtl/core/utv_checker.sv =====
`include "utf8_stream_validator_macros.svh"

module utv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic       stream_valid
);

	// A waiting verdict stays put until it is popped.
	`UTV_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(stream_valid))

	// The byte queue can only fill behind a verdict that is still waiting.
	`UTV_ASSERT_NOW(a_full_needs_result, full, !empty)

	// A first verdict is never shown while the byte queue is full.
	`UTV_ASSERT_NOW(a_first_result_not_full, $fell(empty), !full)

endmodule

bind utf8_stream_validator utv_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	typedef enum int {
		FLAW_NONE,
		FLAW_OVERLONG,
		FLAW_SURROGATE,
		FLAW_TOO_BIG,
		FLAW_BAD_LEAD,
		FLAW_BAD_CONT,
		FLAW_CUT
	} flaw_t;

	class verdict_board;
		logic [1:0]  remaining;
		logic [1:0]  seq_len;
		logic [20:0] point;
		logic        bad;
		logic        verdicts[$];
		int unsigned mismatches;

		function new();
			clear_stream();
			mismatches = 0;
		endfunction

		function void clear_stream();
			remaining = 2'd0;
			seq_len = 2'd0;
			point = 21'd0;
			bad = 1'b0;
		endfunction

		function bit point_legal(logic [1:0] len, logic [20:0] cp);
			if (len == 2'd1 && cp < 21'h80) return 1'b0;
			if (len == 2'd2 && cp < 21'h800) return 1'b0;
			if (len == 2'd3 && cp < 21'h10000) return 1'b0;
			if (cp > 21'h10FFFF) return 1'b0;
			if (cp >= 21'hD800 && cp <= 21'hDFFF) return 1'b0;
			return 1'b1;
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			if (remaining == 2'd0) begin
				casez (b)
					8'b0???????: begin
					end
					8'b110?????: begin
						remaining = 2'd1;
						seq_len = 2'd1;
						point = {16'd0, b[4:0]};
					end
					8'b1110????: begin
						remaining = 2'd2;
						seq_len = 2'd2;
						point = {17'd0, b[3:0]};
					end
					8'b11110???: begin
						remaining = 2'd3;
						seq_len = 2'd3;
						point = {18'd0, b[2:0]};
					end
					default: begin
						bad = 1'b1;
					end
				endcase
			end else if (b[7:6] != 2'b10) begin
				bad = 1'b1;
				remaining = 2'd0;
				seq_len = 2'd0;
				point = 21'd0;
			end else begin
				point = {point[14:0], b[5:0]};
				remaining = remaining - 2'd1;
				if (remaining == 2'd0) begin
					if (!point_legal(seq_len, point)) bad = 1'b1;
					seq_len = 2'd0;
					point = 21'd0;
				end
			end
			if (fin) begin
				verdicts.insert(verdicts.size(), !bad && remaining == 2'd0);
				clear_stream();
			end
		endfunction

		function void check_verdict(logic actual);
			logic want;
			if (verdicts.size() == 0) begin
				$error("stream_valid: no verdict expected, actual %0b", actual);
				mismatches++;
				return;
			end
			want = verdicts.pop_front();
			if (actual !== want) begin
				$error("stream_valid mismatch: expected %0b, actual %0b", want, actual);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return verdicts.size();
		endfunction
	endclass

	localparam int NUM_DIRECTED = 24;
	localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
		{1'b1, 8'h7F},
		{1'b0, 8'hC2}, {1'b1, 8'h80},
		{1'b0, 8'hC0}, {1'b1, 8'hAF},
		{1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b1, 8'h80},
		{1'b0, 8'hF4}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b1, 8'h80},
		{1'b0, 8'hF4}, {1'b0, 8'h8F}, {1'b0, 8'hBF}, {1'b1, 8'hBF},
		{1'b1, 8'h80},
		{1'b1, 8'hFF},
		{1'b1, 8'hF8},
		{1'b0, 8'hC3}, {1'b0, 8'h41}, {1'b1, 8'h00},
		{1'b0, 8'hE2}, {1'b1, 8'h82}
	};
	localparam int RANDOM_BYTES = 800;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'd0;
	logic       final_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       stream_valid;

	int unsigned  send_idle_pct = 15;
	int unsigned  recv_idle_pct = 15;
	int unsigned  bytes_sent = 0;
	verdict_board board = new();

	utf8_stream_validator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.empty(empty),
		.pop(pop),
		.stream_valid(stream_valid)
	);

	always #5 clk = ~clk;

	task automatic send_byte(input logic [7:0] d, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= d;
		final_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_byte(d, fin);
		bytes_sent++;
	endtask

	task automatic drain_verdicts();
		push <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	task automatic add_char(ref logic [7:0] seq[$], input flaw_t flaw);
		int          len;
		int          drop;
		int          pos;
		logic [20:0] cp;
		logic [7:0]  enc[$];
		logic [7:0]  junk;
		if (flaw == FLAW_BAD_LEAD) begin
			seq.insert(seq.size(), $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
				: 8'($urandom_range(8'hF8, 8'hFF)));
			return;
		end
		case (flaw)
			FLAW_OVERLONG: begin
				len = $urandom_range(2, 4);
				cp = (len == 2) ? 21'($urandom_range(0, 21'h7F))
					: (len == 3) ? 21'($urandom_range(0, 21'h7FF))
					: 21'($urandom_range(0, 21'hFFFF));
			end
			FLAW_SURROGATE: begin
				len = 3;
				cp = 21'($urandom_range(21'hD800, 21'hDFFF));
			end
			FLAW_TOO_BIG: begin
				len = 4;
				cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
			end
			default: begin
				len = (flaw == FLAW_NONE) ? $urandom_range(1, 4) : $urandom_range(2, 4);
				case (len)
					1: cp = 21'($urandom_range(0, 21'h7F));
					2: cp = 21'($urandom_range(21'h80, 21'h7FF));
					3: cp = $urandom_range(1) ? 21'($urandom_range(21'h800, 21'hD7FF))
						: 21'($urandom_range(21'hE000, 21'hFFFF));
					default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
				endcase
			end
		endcase
		case (len)
			1: enc.insert(enc.size(), {1'b0, cp[6:0]});
			2: begin
				enc.insert(enc.size(), {3'b110, cp[10:6]});
				enc.insert(enc.size(), {2'b10, cp[5:0]});
			end
			3: begin
				enc.insert(enc.size(), {4'b1110, cp[15:12]});
				enc.insert(enc.size(), {2'b10, cp[11:6]});
				enc.insert(enc.size(), {2'b10, cp[5:0]});
			end
			default: begin
				enc.insert(enc.size(), {5'b11110, cp[20:18]});
				enc.insert(enc.size(), {2'b10, cp[17:12]});
				enc.insert(enc.size(), {2'b10, cp[11:6]});
				enc.insert(enc.size(), {2'b10, cp[5:0]});
			end
		endcase
		if (flaw == FLAW_BAD_CONT) begin
			pos = $urandom_range(1, len - 1);
			junk = 8'($urandom);
			if (junk[7:6] == 2'b10) junk[6] = 1'b1;
			enc[pos] = junk;
		end else if (flaw == FLAW_CUT) begin
			drop = $urandom_range(1, len - 1);
			repeat (drop) void'(enc.pop_back());
		end
		foreach (enc[i]) seq.insert(seq.size(), enc[i]);
	endtask

	task automatic send_random_stream();
		logic [7:0] seq[$];
		int         kind;
		int         nchars;
		flaw_t      flaw;
		kind = $urandom_range(99);
		nchars = $urandom_range(1, 8);
		if (kind < 10) begin
			repeat ($urandom_range(1, 6)) seq.insert(seq.size(), 8'($urandom));
		end else begin
			for (int c = 0; c < nchars; c++) begin
				flaw = FLAW_NONE;
				if (kind >= 60 && $urandom_range(99) < 25) begin
					flaw = flaw_t'($urandom_range(FLAW_OVERLONG, FLAW_BAD_CONT));
					if (c == nchars - 1 && $urandom_range(2) == 0) flaw = FLAW_CUT;
				end
				add_char(seq, flaw);
			end
		end
		foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) board.check_verdict(stream_valid);
			pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int unsigned waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		drain_verdicts();

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= 250 && bytes_sent < 400) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = 15;
				recv_idle_pct = 15;
			end
			if (bytes_sent >= 500 && bytes_sent < 520) drain_verdicts();
			send_random_stream();
		end

		push <= 1'b0;
		waited = 0;
		while (board.outstanding() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (board.outstanding() != 0)
			$error("stream_valid: %0d verdicts never arrived", board.outstanding());
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
